// ===== src/sue_pkg.sv =====
// ----------------------------------------------------------------------------
// sue_pkg
// Shared types and constants for the string unescaper with FNV-1a hash.
// ----------------------------------------------------------------------------
`default_nettype none

package sue_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_BRACE  = 8'h7B;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_T      = 8'h74;
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   // held opener kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BSLASH = 2'd1;
   localparam logic [1:0] KIND_BRACE  = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [31:0] str_hash;
   } rsp_payload_type;

   // decode of one request against the held opener
   typedef struct packed {
      logic       hold;       // opener is held, no output
      logic [1:0] hold_kind;
      logic       two;        // two output bytes
      logic [7:0] byte0;
      logic [7:0] byte1;
   } decode_type;

endpackage

`default_nettype wire

// ===== src/sue_escape_decode.sv =====
// ----------------------------------------------------------------------------
// sue_escape_decode
// Maps one raw byte and the held opener to zero, one or two output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sue_escape_decode (
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   input  wire logic [1:0]         pending_kind,
   output sue_pkg::decode_type     decode
);

   always_comb begin
      decode           = '0;
      decode.hold_kind = sue_pkg::KIND_NONE;
      decode.byte0     = in_byte;
      decode.byte1     = in_byte;
      case (pending_kind)
         sue_pkg::KIND_BSLASH: begin
            case (in_byte)
               sue_pkg::CHR_SQUOTE: decode.byte0 = sue_pkg::CHR_SQUOTE;
               sue_pkg::CHR_DQUOTE: decode.byte0 = sue_pkg::CHR_DQUOTE;
               sue_pkg::CHR_BSLASH: decode.byte0 = sue_pkg::CHR_BSLASH;
               sue_pkg::CHR_T:      decode.byte0 = sue_pkg::CHR_TAB;
               sue_pkg::CHR_N:      decode.byte0 = sue_pkg::CHR_LF;
               sue_pkg::CHR_R:      decode.byte0 = sue_pkg::CHR_CR;
               default: begin
                  decode.two   = 1'b1;
                  decode.byte0 = sue_pkg::CHR_BSLASH;
               end
            endcase
         end
         sue_pkg::KIND_BRACE: begin
            decode.byte0 = sue_pkg::CHR_BRACE;
            decode.two   = (in_byte != sue_pkg::CHR_BRACE);
         end
         default: begin
            // nothing held; a non-final opener is parked
            if (!in_last && (in_byte == sue_pkg::CHR_BSLASH)) begin
               decode.hold      = 1'b1;
               decode.hold_kind = sue_pkg::KIND_BSLASH;
            end else if (!in_last && (in_byte == sue_pkg::CHR_BRACE)) begin
               decode.hold      = 1'b1;
               decode.hold_kind = sue_pkg::KIND_BRACE;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sue_fnv_round.sv =====
// ----------------------------------------------------------------------------
// sue_fnv_round
// One FNV-1a round: xor the byte into the hash, multiply by the prime.
// ----------------------------------------------------------------------------
`default_nettype none

module sue_fnv_round (
   input  wire logic [31:0] hash_cur,
   input  wire logic [7:0]  data_byte,
   output logic [31:0]      hash_next
);

   logic [31:0] mixed;

   assign mixed     = hash_cur ^ {24'd0, data_byte};
   assign hash_next = mixed * sue_pkg::FNV_PRIME;

endmodule

`default_nettype wire

// ===== src/string_unescape_fnv_hash.sv =====
// ----------------------------------------------------------------------------
// string_unescape_fnv_hash
// Escape decoder for string literals with a running FNV-1a 32-bit hash.
// ----------------------------------------------------------------------------
// Usage:
//   Raw literal bytes enter on req_* one request at a time, in_last on the
//   final byte. Decoded bytes leave on rsp_*; str_hash carries the hash of
//   the whole decoded literal on the result with out_last, and 0 otherwise.
//   A request yields zero to two results. A held opener (backslash or brace
//   that is not final) is taken with no result.
//   Each result passes through the single shared FNV round unit (ST_HASH)
//   and then the output register (ST_SEND), so a request is not accepted
//   until every result of the one before has been taken. req_stall is high
//   from accept until the last result of that request has been taken.
//   A stall on rsp holds the result steady in the output register and
//   delays everything behind it.
//   Reset clears the held opener and loads the hash with the offset basis;
//   the hash returns to the basis after every final result.
// ----------------------------------------------------------------------------
`default_nettype none

module string_unescape_fnv_hash (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire sue_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output sue_pkg::rsp_payload_type      rsp_payload
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HASH = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  pending_ff, pending_in;
   logic [31:0] hash_ff, hash_in;
   logic        second_ff, second_in;   // working on the second byte
   logic        two_ff, two_in;
   logic        last_ff, last_in;
   logic [7:0]  byte0_ff, byte0_in;
   logic [7:0]  byte1_ff, byte1_in;
   sue_pkg::rsp_payload_type rsp_ff, rsp_in;

   sue_pkg::decode_type decode;
   logic                req_accept;
   logic [7:0]          cur_byte;
   logic [31:0]         hash_next;
   logic                final_out;

   sue_escape_decode u_decode (
      .in_byte      (req_payload.in_byte),
      .in_last      (req_payload.in_last),
      .pending_kind (pending_ff),
      .decode       (decode)
   );

   sue_fnv_round u_fnv (
      .hash_cur  (hash_ff),
      .data_byte (cur_byte),
      .hash_next (hash_next)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_SEND);
   assign rsp_payload = rsp_ff;

   assign cur_byte  = second_ff ? byte1_ff : byte0_ff;
   assign final_out = last_ff && (second_ff || !two_ff);

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      hash_in    = hash_ff;
      second_in  = second_ff;
      two_in     = two_ff;
      last_in    = last_ff;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (decode.hold) begin
                  pending_in = decode.hold_kind;
               end else begin
                  pending_in = sue_pkg::KIND_NONE;
                  byte0_in   = decode.byte0;
                  byte1_in   = decode.byte1;
                  two_in     = decode.two;
                  last_in    = req_payload.in_last;
                  second_in  = 1'b0;
                  state_in   = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            rsp_in.out_byte = cur_byte;
            rsp_in.out_last = final_out;
            rsp_in.str_hash = final_out ? hash_next : 32'd0;
            hash_in         = final_out ? sue_pkg::FNV_BASIS : hash_next;
            state_in        = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (two_ff && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = ST_HASH;
               end else begin
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= sue_pkg::KIND_NONE;
         hash_ff    <= sue_pkg::FNV_BASIS;
         second_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         hash_ff    <= hash_in;
         second_ff  <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      two_ff   <= two_in;
      last_ff  <= last_in;
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== verif/string_unescape_fnv_hash_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_unescape_fnv_hash_tb
// Self-checking bench for the string unescaper with its FNV-1a hash.
// A short table of literals (byte extremes, every escape, brace pairs and
// trailing openers) is followed by random literals with some loose noise
// requests. A behavioral decoder predicts every decoded byte and the hash,
// and a scoreboard checks each result in order while both sides idle at
// random.
// ----------------------------------------------------------------------------

module string_unescape_fnv_hash_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 80;
   localparam int PHASE_REQS     = 460;
   localparam int DRAIN_CYCLES   = 20;

   localparam sue_pkg::rsp_payload_type NO_RSP = '0;

   typedef struct {
      logic [7:0]               raw;
      logic                     final_byte;
      logic                     known;       // rsp holds the typed-in result
      sue_pkg::rsp_payload_type rsp;
   } directed_row_type;

   // hashes of one-byte literals: 0x00, 0xFF, 'a'
   directed_row_type directed_rows [25] = '{
      '{8'h00,               1'b1, 1'b1, {8'h00, 1'b1, 32'h050C5D1F}},
      '{8'hFF,               1'b1, 1'b1, {8'hFF, 1'b1, 32'h7A0B824E}},
      '{8'h61,               1'b1, 1'b1, {8'h61, 1'b1, 32'hE40C292C}},
      '{sue_pkg::CHR_BSLASH, 1'b1, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BRACE,  1'b1, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_SQUOTE, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_DQUOTE, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_T,      1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_N,      1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_R,      1'b1, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{8'h71,               1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BRACE,  1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BRACE,  1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BRACE,  1'b0, 1'b0, NO_RSP},
      '{8'h78,               1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BSLASH, 1'b0, 1'b0, NO_RSP},
      '{sue_pkg::CHR_BRACE,  1'b1, 1'b0, NO_RSP}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   sue_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   sue_pkg::rsp_payload_type rsp_payload;

   // decoder state mirrored by the bench
   logic [1:0]  held_kind = sue_pkg::KIND_NONE;
   logic [31:0] hash_acc  = sue_pkg::FNV_BASIS;

   sue_pkg::rsp_payload_type decoded_bytes_q [$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_trigger  = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   int requests_sent   = 0;
   int results_checked = 0;
   int literals_done   = 0;
   int error_count     = 0;

   string_unescape_fnv_hash i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one decoded byte: advance the hash, report it only on the final byte
   function automatic sue_pkg::rsp_payload_type fnv_emit(input logic [7:0] b,
                                                         input logic is_last);
      sue_pkg::rsp_payload_type r;
      hash_acc   = (hash_acc ^ {24'd0, b}) * sue_pkg::FNV_PRIME;
      r.out_byte = b;
      r.out_last = is_last;
      r.str_hash = is_last ? hash_acc : 32'd0;
      return r;
   endfunction

   function automatic int unsigned unescape_step(input sue_pkg::req_payload_type r,
                                                 output sue_pkg::rsp_payload_type o0,
                                                 output sue_pkg::rsp_payload_type o1);
      logic [7:0]  dec;
      logic        single_out;
      int unsigned n;
      o0 = '0;
      o1 = '0;
      dec = '0;
      single_out = 1'b1;
      n = 0;
      case (held_kind)
         sue_pkg::KIND_BSLASH: begin
            case (r.in_byte)
               sue_pkg::CHR_SQUOTE, sue_pkg::CHR_DQUOTE, sue_pkg::CHR_BSLASH:
                  dec = r.in_byte;
               sue_pkg::CHR_T: dec = sue_pkg::CHR_TAB;
               sue_pkg::CHR_N: dec = sue_pkg::CHR_LF;
               sue_pkg::CHR_R: dec = sue_pkg::CHR_CR;
               default: single_out = 1'b0;
            endcase
            if (single_out) begin
               o0 = fnv_emit(dec, r.in_last);
               n = 1;
            end else begin
               o0 = fnv_emit(sue_pkg::CHR_BSLASH, 1'b0);
               o1 = fnv_emit(r.in_byte, r.in_last);
               n = 2;
            end
         end
         sue_pkg::KIND_BRACE: begin
            if (r.in_byte == sue_pkg::CHR_BRACE) begin
               o0 = fnv_emit(sue_pkg::CHR_BRACE, r.in_last);
               n = 1;
            end else begin
               o0 = fnv_emit(sue_pkg::CHR_BRACE, 1'b0);
               o1 = fnv_emit(r.in_byte, r.in_last);
               n = 2;
            end
         end
         default: begin
            // opener that is not final waits for its partner
            if (!r.in_last && (r.in_byte == sue_pkg::CHR_BSLASH ||
                               r.in_byte == sue_pkg::CHR_BRACE)) begin
               held_kind = (r.in_byte == sue_pkg::CHR_BSLASH) ? sue_pkg::KIND_BSLASH
                                                              : sue_pkg::KIND_BRACE;
               return 0;
            end
            o0 = fnv_emit(r.in_byte, r.in_last);
            n = 1;
         end
      endcase
      held_kind = sue_pkg::KIND_NONE;
      if (r.in_last) begin
         hash_acc = sue_pkg::FNV_BASIS;
      end
      return n;
   endfunction

   // offer one request, wait for the handshake, then queue what it decodes to
   task automatic offer_request(input sue_pkg::req_payload_type p, input logic known,
                                input sue_pkg::rsp_payload_type known_rsp);
      sue_pkg::rsp_payload_type o0;
      sue_pkg::rsp_payload_type o1;
      int unsigned              n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      n = unescape_step(p, o0, o1);
      if (known) begin
         decoded_bytes_q.push_back(known_rsp);
      end else begin
         if (n > 0) decoded_bytes_q.push_back(o0);
         if (n > 1) decoded_bytes_q.push_back(o1);
      end
      requests_sent++;
   endtask

   // sender pauses until every decoded byte has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_bytes_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_trigger != hold_taken) begin
         hold_taken <= hold_trigger;
         hold_left  <= LONG_HOLD;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // scoreboard
   always @(posedge clock) begin
      sue_pkg::rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (decoded_bytes_q.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = decoded_bytes_q.pop_front();
            if (rsp_payload.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.out_byte, rsp_payload.out_byte);
               error_count++;
            end
            if (rsp_payload.out_last !== want.out_last) begin
               $display("%0t: out_last expected %0b actual %0b",
                        $time, want.out_last, rsp_payload.out_last);
               error_count++;
            end
            if (rsp_payload.str_hash !== want.str_hash) begin
               $display("%0t: str_hash expected %08h actual %08h",
                        $time, want.str_hash, rsp_payload.str_hash);
               error_count++;
            end
            results_checked++;
            if (want.out_last) literals_done++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sue_pkg::req_payload_type p;
      logic [7:0]               lit_bytes [$];
      int                       phase_start;
      int                       len;
      bit                       hold_done;
      hold_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rcv_idle_pct  = 55;
      foreach (directed_rows[i]) begin
         p.in_byte = directed_rows[i].raw;
         p.in_last = directed_rows[i].final_byte;
         offer_request(p, directed_rows[i].known, directed_rows[i].rsp);
      end
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 55 : 0;
         rcv_idle_pct  = (phase == 0) ? 55 : (phase == 1) ? 20 : 0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQS) begin
            // receiver holds off while the sender keeps offering
            if (phase == 2 && !hold_done && requests_sent - phase_start > 100) begin
               hold_trigger++;
               hold_done = 1'b1;
            end
            lit_bytes.delete();
            if ($urandom_range(9) == 0) begin
               // loose request, may leave an opener held across literals
               p.in_byte = 8'($urandom_range(255));
               p.in_last = 1'($urandom_range(1));
               offer_request(p, 1'b0, NO_RSP);
            end else begin
               len = $urandom_range(1, 8);
               for (int k = 0; k < len; k++) begin
                  case ($urandom_range(4))
                     0: begin
                        lit_bytes.push_back(sue_pkg::CHR_BSLASH);
                        case ($urandom_range(6))
                           0: lit_bytes.push_back(sue_pkg::CHR_SQUOTE);
                           1: lit_bytes.push_back(sue_pkg::CHR_DQUOTE);
                           2: lit_bytes.push_back(sue_pkg::CHR_BSLASH);
                           3: lit_bytes.push_back(sue_pkg::CHR_T);
                           4: lit_bytes.push_back(sue_pkg::CHR_N);
                           5: lit_bytes.push_back(sue_pkg::CHR_R);
                           default: lit_bytes.push_back(8'($urandom_range(255)));
                        endcase
                     end
                     1: begin
                        lit_bytes.push_back(sue_pkg::CHR_BRACE);
                        lit_bytes.push_back($urandom_range(1) ? sue_pkg::CHR_BRACE
                                                              : 8'($urandom_range(255)));
                     end
                     default: lit_bytes.push_back(8'($urandom_range(255)));
                  endcase
               end
               // sometimes end on a lone opener
               if ($urandom_range(7) == 0) begin
                  lit_bytes.push_back($urandom_range(1) ? sue_pkg::CHR_BSLASH
                                                        : sue_pkg::CHR_BRACE);
               end
               foreach (lit_bytes[i]) begin
                  p.in_byte = lit_bytes[i];
                  p.in_last = (i == lit_bytes.size() - 1);
                  offer_request(p, 1'b0, NO_RSP);
               end
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests; checked %0d decoded bytes over %0d literals,",
               requests_sent, results_checked, literals_done);
      $display("with random idling on both sides, a long receiver hold and drain pauses.");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
